// ===== rtl/ffba_pkg.sv =====
package ffba_pkg;

  // Default sizes of the block table and of the vertex and index fields
  localparam int unsigned MAX_BLOCKS_DEF  = 16;
  localparam int unsigned VERTEX_BITS_DEF = 16;
  localparam int unsigned INDEX_BITS_DEF  = 20;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  // Request commands; the remaining code is answered as not found
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_FIT     = 2'd2
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED    = 3'd0,
    ST_NEW       = 3'd1,
    ST_DONE      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TOO_SMALL = 3'd4,
    ST_NO_SPACE  = 3'd5
  } status_e;

  // Configuration register indexes
  typedef enum logic {
    REG_VERTEX_CAP = 1'b0,
    REG_INDEX_CAP  = 1'b1
  } reg_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // capture the request, restart the table scan
    logic scan;    // read one entry and check the previous one
    logic finish;  // update the table and load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;       // the entry checked this cycle matches
    logic scan_end;  // every used entry was checked without a match
    logic out_free;  // the result register can take a new result
  } dp_stat_t;

endpackage

// ===== rtl/first_fit_block_allocator_core.sv =====
// Channel    Direction  Handshake               Contents
// s_axis     in         tvalid/tready           request: tuser command, tdata sizes
// m_axis     out        tvalid/tready           result: tuser status, tdata starts
// apb        in         psel/penable/pready     vertex and index capacity registers
//
// A request is accepted, then the used entries are read one entry per cycle
// from the single RAM read port with registered read data, the end of the
// scan is seen, and a last step writes back and loads the result. A match
// ends the scan early. Reset clears the entry count, the tails and sets both
// capacities to all ones; the table RAM needs no clearing.
// The result register lets the next request enter while a result is not
// taken; a second result waits in the write-back step until the first leaves.
module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned VERTEX_BITS = ffba_pkg::VERTEX_BITS_DEF,
  parameter int unsigned INDEX_BITS  = ffba_pkg::INDEX_BITS_DEF,
  localparam int unsigned IN_DW  = 2 * VERTEX_BITS + INDEX_BITS,
  localparam int unsigned IN_TW  = ((IN_DW + 7) / 8) * 8,
  localparam int unsigned OUT_DW = 2 * VERTEX_BITS + 2 * INDEX_BITS,
  localparam int unsigned OUT_TW = ((OUT_DW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // vertex_start_in, vertex_need, index_need (lowest first)
  input  logic [IN_TW-1:0]              s_axis_tdata,
  // command
  input  logic [ffba_pkg::CMD_W-1:0]    s_axis_tuser,
  // Results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // vertex_start_out, index_start_out, vertex_count_out, index_count_out
  output logic [OUT_TW-1:0]             m_axis_tdata,
  // status
  output logic [ffba_pkg::STATUS_W-1:0] m_axis_tuser,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffba_pkg::CFG_AW-1:0]   paddr,
  input  logic [ffba_pkg::CFG_DW-1:0]   pwdata,
  output logic [ffba_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned VB = VERTEX_BITS;
  localparam int unsigned IB = INDEX_BITS;

  ffba_pkg::ctrl_cmd_t ctrl_cmd;
  ffba_pkg::dp_stat_t  dp_stat;

  logic [VB-1:0] out_vs, out_vc;
  logic [IB-1:0] out_is, out_ic;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  ffba_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .VERTEX_BITS (VERTEX_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .req_cmd_i    (s_axis_tuser),
    .req_vs_i     (s_axis_tdata[0 +: VB]),
    .req_vneed_i  (s_axis_tdata[VB +: VB]),
    .req_ineed_i  (s_axis_tdata[2*VB +: IB]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_vs_o     (out_vs),
    .out_is_o     (out_is),
    .out_vc_o     (out_vc),
    .out_ic_o     (out_ic),
    .cfg_we_i     (psel && penable && pwrite),
    .cfg_sel_i    (paddr[2]),
    .cfg_wdata_i  (pwdata),
    .cfg_rdata_o  (prdata)
  );

  // Pack the result fields, zero fill up to whole bytes
  assign m_axis_tdata = OUT_TW'({out_ic, out_vc, out_is, out_vs});
  assign pready       = 1'b1;

endmodule

// ===== rtl/ffba_ram.sv =====
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ffba_ctrl.sv =====
module ffba_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  ffba_pkg::dp_stat_t    stat_i,
  output ffba_pkg::ctrl_cmd_t   cmd_o
);

  ffba_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one request: accept, scan the table, write back and report
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ffba_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ffba_pkg::S_SCAN;
        end
      end
      ffba_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit || stat_i.scan_end) begin
          state_d = ffba_pkg::S_FINISH;
        end
      end
      ffba_pkg::S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ffba_datapath.sv =====
module ffba_datapath #(
  parameter int unsigned MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned VERTEX_BITS = ffba_pkg::VERTEX_BITS_DEF,
  parameter int unsigned INDEX_BITS  = ffba_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffba_pkg::ctrl_cmd_t           cmd_i,
  output ffba_pkg::dp_stat_t            stat_o,
  // Request payload
  input  logic [ffba_pkg::CMD_W-1:0]    req_cmd_i,
  input  logic [VERTEX_BITS-1:0]        req_vs_i,
  input  logic [VERTEX_BITS-1:0]        req_vneed_i,
  input  logic [INDEX_BITS-1:0]         req_ineed_i,
  // Result register
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffba_pkg::STATUS_W-1:0] out_status_o,
  output logic [VERTEX_BITS-1:0]        out_vs_o,
  output logic [INDEX_BITS-1:0]         out_is_o,
  output logic [VERTEX_BITS-1:0]        out_vc_o,
  output logic [INDEX_BITS-1:0]         out_ic_o,
  // Configuration registers
  input  logic                          cfg_we_i,
  input  logic                          cfg_sel_i,
  input  logic [ffba_pkg::CFG_DW-1:0]   cfg_wdata_i,
  output logic [ffba_pkg::CFG_DW-1:0]   cfg_rdata_o
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned VB = VERTEX_BITS;
  localparam int unsigned IB = INDEX_BITS;
  // Entry word, lowest bits first: index size, index start, vertex size,
  // vertex start, free mark
  localparam int unsigned ISZ_LO = 0;
  localparam int unsigned IST_LO = IB;
  localparam int unsigned VSZ_LO = 2 * IB;
  localparam int unsigned VST_LO = 2 * IB + VB;
  localparam int unsigned FREE_B = 2 * IB + 2 * VB;
  localparam int unsigned WW     = 2 * IB + 2 * VB + 1;

  // Request registers
  logic [ffba_pkg::CMD_W-1:0] cmd_q;
  logic [VB-1:0]              vs_q, vneed_q;
  logic [IB-1:0]              ineed_q;

  // Allocator state and configuration
  logic [CW-1:0] used_q;
  logic [VB-1:0] vtail_q, vcap_q;
  logic [IB-1:0] itail_q, icap_q;

  // Scan state
  logic [CW-1:0] idx_q;
  logic [AW-1:0] cmp_idx_q, found_idx_q;
  logic          pend_q, found_q;
  logic [WW-1:0] found_word_q;

  // Result register
  logic                          out_valid_q;
  logic [ffba_pkg::STATUS_W-1:0] out_status_q;
  logic [VB-1:0]                 out_vs_q, out_vc_q;
  logic [IB-1:0]                 out_is_q, out_ic_q;

  logic          issue;
  logic [WW-1:0] rdata;
  logic          match, hit;
  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata;

  logic                 append, no_space;
  logic [VB:0]          vtail_sum;
  logic [IB:0]          itail_sum;
  ffba_pkg::status_e    res_status;
  logic [VB-1:0]        res_vs;
  logic [IB-1:0]        res_is;

  // Table of entries
  ffba_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Read the next used entry while scanning
  assign issue = cmd_i.scan && (idx_q < used_q);

  // Check the entry read in the previous cycle
  always_comb begin
    match = 1'b0;
    case (cmd_q)
      ffba_pkg::CMD_ALLOC: begin
        match = rdata[FREE_B]
             && (rdata[VSZ_LO +: VB] >= vneed_q)
             && (rdata[ISZ_LO +: IB] >= ineed_q);
      end
      ffba_pkg::CMD_RELEASE,
      ffba_pkg::CMD_FIT: begin
        match = (rdata[VST_LO +: VB] == vs_q);
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  assign hit = cmd_i.scan && pend_q && match;

  assign stat_o.hit      = hit;
  assign stat_o.scan_end = !pend_q && (idx_q >= used_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Capture the request and track the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      idx_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (cmd_i.scan) begin
      pend_q <= issue;
      if (issue) begin
        idx_q <= idx_q + CW'(1);
      end
      if (hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q   <= req_cmd_i;
      vs_q    <= req_vs_i;
      vneed_q <= req_vneed_i;
      ineed_q <= req_ineed_i;
    end
    if (issue) begin
      cmp_idx_q <= idx_q[AW-1:0];
    end
    if (hit) begin
      found_idx_q  <= cmp_idx_q;
      found_word_q <= rdata;
    end
  end

  // Work out the result and the table update
  assign vtail_sum = {1'b0, vtail_q} + {1'b0, vneed_q};
  assign itail_sum = {1'b0, itail_q} + {1'b0, ineed_q};
  assign no_space  = (used_q >= CW'(MAX_BLOCKS))
                  || (vtail_sum > {1'b0, vcap_q})
                  || (itail_sum > {1'b0, icap_q});

  always_comb begin
    res_status = ffba_pkg::ST_NOT_FOUND;
    res_vs     = '0;
    res_is     = '0;
    append     = 1'b0;
    we         = 1'b0;
    waddr      = found_idx_q;
    wdata      = found_word_q;
    case (cmd_q)
      ffba_pkg::CMD_ALLOC: begin
        if (found_q) begin
          res_status    = ffba_pkg::ST_REUSED;
          res_vs        = found_word_q[VST_LO +: VB];
          res_is        = found_word_q[IST_LO +: IB];
          we            = cmd_i.finish;
          wdata[FREE_B] = 1'b0;
        end else if (no_space) begin
          res_status = ffba_pkg::ST_NO_SPACE;
        end else begin
          res_status = ffba_pkg::ST_NEW;
          res_vs     = vtail_q;
          res_is     = itail_q;
          append     = cmd_i.finish;
          we         = cmd_i.finish;
          waddr      = used_q[AW-1:0];
          wdata      = {1'b0, vtail_q, vneed_q, itail_q, ineed_q};
        end
      end
      ffba_pkg::CMD_RELEASE: begin
        if (found_q) begin
          res_status    = ffba_pkg::ST_DONE;
          res_vs        = found_word_q[VST_LO +: VB];
          res_is        = found_word_q[IST_LO +: IB];
          we            = cmd_i.finish;
          wdata[FREE_B] = 1'b1;
        end
      end
      ffba_pkg::CMD_FIT: begin
        if (found_q) begin
          res_vs = found_word_q[VST_LO +: VB];
          res_is = found_word_q[IST_LO +: IB];
          if ((found_word_q[VSZ_LO +: VB] < vneed_q)
              || (found_word_q[ISZ_LO +: IB] < ineed_q)) begin
            res_status = ffba_pkg::ST_TOO_SMALL;
          end else begin
            res_status = ffba_pkg::ST_DONE;
          end
        end
      end
      default: begin
        res_status = ffba_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Advance the tails and the entry count on a new block; take config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      vtail_q <= '0;
      itail_q <= '0;
      vcap_q  <= '1;
      icap_q  <= '1;
    end else begin
      if (append) begin
        used_q  <= used_q + CW'(1);
        vtail_q <= vtail_sum[VB-1:0];
        itail_q <= itail_sum[IB-1:0];
      end
      if (cfg_we_i) begin
        case (cfg_sel_i)
          ffba_pkg::REG_VERTEX_CAP: vcap_q <= cfg_wdata_i[VB-1:0];
          ffba_pkg::REG_INDEX_CAP:  icap_q <= cfg_wdata_i[IB-1:0];
          default: begin
            vcap_q <= vcap_q;
          end
        endcase
      end
    end
  end

  assign cfg_rdata_o = (cfg_sel_i == ffba_pkg::REG_INDEX_CAP)
                     ? ffba_pkg::CFG_DW'(icap_q) : ffba_pkg::CFG_DW'(vcap_q);

  // Load the result register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_vs_q     <= res_vs;
      out_is_q     <= res_is;
      out_vc_q     <= vneed_q;
      out_ic_q     <= ineed_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_vs_o     = out_vs_q;
  assign out_is_o     = out_is_q;
  assign out_vc_o     = out_vc_q;
  assign out_ic_o     = out_ic_q;

endmodule
